/* rtl/core/six_register_instruction_executor_defines.svh */
// Shared assertion macros for the instruction executor.
// Both expect clk and rst_n in the scope of use.
`ifndef SIX_REGISTER_INSTRUCTION_EXECUTOR_DEFINES_SVH
`define SIX_REGISTER_INSTRUCTION_EXECUTOR_DEFINES_SVH

// same-cycle implication
`define SRIE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SRIE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/srie_pkg.sv */
package srie_pkg;

    localparam int DEF_REGISTER_COUNT = 6;

    localparam int DATA_W    = 64;
    localparam int OPCODE_W  = 4;
    localparam int OPERAND_W = 32;
    localparam int DEST_W    = 3;

    localparam int IP_SEL_W   = 3;
    localparam int PROG_LEN_W = 16;
    localparam int INIT_R0_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_IP_SELECT   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PROG_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_R0     = 2'd2;

    localparam logic [OPCODE_W-1:0] OP_ADDR = 4'd0;
    localparam logic [OPCODE_W-1:0] OP_ADDI = 4'd1;
    localparam logic [OPCODE_W-1:0] OP_MULR = 4'd2;
    localparam logic [OPCODE_W-1:0] OP_MULI = 4'd3;
    localparam logic [OPCODE_W-1:0] OP_BANR = 4'd4;
    localparam logic [OPCODE_W-1:0] OP_BANI = 4'd5;
    localparam logic [OPCODE_W-1:0] OP_BORR = 4'd6;
    localparam logic [OPCODE_W-1:0] OP_BORI = 4'd7;
    localparam logic [OPCODE_W-1:0] OP_SETR = 4'd8;
    localparam logic [OPCODE_W-1:0] OP_SETI = 4'd9;
    localparam logic [OPCODE_W-1:0] OP_GTIR = 4'd10;
    localparam logic [OPCODE_W-1:0] OP_GTRI = 4'd11;
    localparam logic [OPCODE_W-1:0] OP_GTRR = 4'd12;
    localparam logic [OPCODE_W-1:0] OP_EQIR = 4'd13;
    localparam logic [OPCODE_W-1:0] OP_EQRI = 4'd14;
    localparam logic [OPCODE_W-1:0] OP_EQRR = 4'd15;

    typedef struct packed {
        logic [OPCODE_W-1:0]         opcode;
        logic signed [OPERAND_W-1:0] operand_a;
        logic signed [OPERAND_W-1:0] operand_b;
        logic [DEST_W-1:0]           dest_index;
    } item_t;

    function automatic logic [DATA_W-1:0] sext32(input logic [OPERAND_W-1:0] v);
        return {{(DATA_W-OPERAND_W){v[OPERAND_W-1]}}, v};
    endfunction

    function automatic logic is_mul(input logic [OPCODE_W-1:0] op);
        return (op == OP_MULR) || (op == OP_MULI);
    endfunction

endpackage

/* rtl/core/srie_ifs.sv */
interface srie_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [srie_pkg::OPCODE_W-1:0]          opcode;
    logic signed [srie_pkg::OPERAND_W-1:0]  operand_a;
    logic signed [srie_pkg::OPERAND_W-1:0]  operand_b;
    logic [srie_pkg::DEST_W-1:0]            dest_index;

    modport source (output valid, output opcode, output operand_a, output operand_b,
                    output dest_index, input ready);
    modport sink   (input valid, input opcode, input operand_a, input operand_b,
                    input dest_index, output ready);
endinterface

interface srie_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [srie_pkg::DATA_W-1:0]   written_value;
    logic signed [srie_pkg::DATA_W-1:0]   next_pointer;
    logic                                 halted;
    logic signed [srie_pkg::DATA_W-1:0]   reg_zero_value;

    modport source (output valid, output written_value, output next_pointer, output halted,
                    output reg_zero_value, input ready);
    modport sink   (input valid, input written_value, input next_pointer, input halted,
                    input reg_zero_value, output ready);
endinterface

/* rtl/core/srie_mul.sv */
// 64x64 -> low 64 multiply split into 32-bit partial products, one register stage.
module srie_mul (
    input  logic                        clk,
    input  logic                        load,
    input  logic [srie_pkg::DATA_W-1:0] a,
    input  logic [srie_pkg::DATA_W-1:0] b,
    output logic [srie_pkg::DATA_W-1:0] product
);

    localparam int HW = srie_pkg::DATA_W / 2;

    logic [srie_pkg::DATA_W-1:0] ll_reg;
    logic [HW-1:0]               cross_reg;
    logic [srie_pkg::DATA_W-1:0] ll_next;
    logic [HW-1:0]               lh;
    logic [HW-1:0]               hl;

    always_comb
    begin
        ll_next = a[HW-1:0] * b[HW-1:0];
        // only the low half of the cross terms survives the wrap
        lh      = HW'(a[HW-1:0] * b[2*HW-1:HW]);
        hl      = HW'(a[2*HW-1:HW] * b[HW-1:0]);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            ll_reg    <= ll_next;
            cross_reg <= lh + hl;
        end
    end

    assign product = ll_reg + {cross_reg, {HW{1'b0}}};

endmodule

/* rtl/core/srie_alu.sv */
module srie_alu (
    input  srie_pkg::item_t             item,
    input  logic [srie_pkg::DATA_W-1:0] va,
    input  logic [srie_pkg::DATA_W-1:0] vb,
    input  logic [srie_pkg::DATA_W-1:0] mul_product,
    output logic [srie_pkg::DATA_W-1:0] res
);

    localparam int DW = srie_pkg::DATA_W;

    logic [DW-1:0] ia;
    logic [DW-1:0] ib;

    assign ia = srie_pkg::sext32(item.operand_a);
    assign ib = srie_pkg::sext32(item.operand_b);

    always_comb
    begin
        unique case (item.opcode)
            srie_pkg::OP_ADDR: res = va + vb;
            srie_pkg::OP_ADDI: res = va + ib;
            srie_pkg::OP_MULR: res = mul_product;
            srie_pkg::OP_MULI: res = mul_product;
            srie_pkg::OP_BANR: res = va & vb;
            srie_pkg::OP_BANI: res = va & ib;
            srie_pkg::OP_BORR: res = va | vb;
            srie_pkg::OP_BORI: res = va | ib;
            srie_pkg::OP_SETR: res = va;
            srie_pkg::OP_SETI: res = ia;
            srie_pkg::OP_GTIR: res = DW'($signed(ia) > $signed(vb));
            srie_pkg::OP_GTRI: res = DW'($signed(va) > $signed(ib));
            srie_pkg::OP_GTRR: res = DW'($signed(va) > $signed(vb));
            srie_pkg::OP_EQIR: res = DW'(ia == vb);
            srie_pkg::OP_EQRI: res = DW'(va == ib);
            srie_pkg::OP_EQRR: res = DW'(va == vb);
            default:           res = '0;
        endcase
    end

endmodule

/* rtl/core/srie_regfile.sv */
// Architectural registers, run state, write-back and pointer update.
module srie_regfile #(
    parameter int REGISTER_COUNT = srie_pkg::DEF_REGISTER_COUNT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            exec_en,
    input  srie_pkg::item_t                 item,
    input  logic [srie_pkg::DATA_W-1:0]     res,
    input  logic [srie_pkg::IP_SEL_W-1:0]   ip_select,
    input  logic [srie_pkg::PROG_LEN_W-1:0] program_length,
    input  logic [srie_pkg::INIT_R0_W-1:0]  initial_reg_zero,
    output logic [srie_pkg::DATA_W-1:0]     va,
    output logic [srie_pkg::DATA_W-1:0]     vb,
    output logic [srie_pkg::DATA_W-1:0]     next_pointer,
    output logic [srie_pkg::DATA_W-1:0]     reg_zero,
    output logic                            halted
);

    localparam int DW    = srie_pkg::DATA_W;
    localparam int IDX_W = $clog2(REGISTER_COUNT);

    logic [DW-1:0] rf_reg    [REGISTER_COUNT];
    logic [DW-1:0] base      [REGISTER_COUNT];
    logic [DW-1:0] after_dst [REGISTER_COUNT];
    logic [DW-1:0] rf_next   [REGISTER_COUNT];
    logic          running_reg;
    logic          running_next;
    logic          a_ok;
    logic          b_ok;
    logic          dst_ok;
    logic          ip_ok;

    always_comb
    begin
        a_ok   = $unsigned(item.operand_a) < 32'(REGISTER_COUNT);
        b_ok   = $unsigned(item.operand_b) < 32'(REGISTER_COUNT);
        dst_ok = 32'(item.dest_index) < 32'(REGISTER_COUNT);
        ip_ok  = 32'(ip_select) < 32'(REGISTER_COUNT);

        // a new run sees cleared registers with r0 preset
        for (int i = 0; i < REGISTER_COUNT; i++)
        begin
            if (running_reg)
                base[i] = rf_reg[i];
            else if (i == 0)
                base[i] = DW'(initial_reg_zero);
            else
                base[i] = '0;
        end

        va = a_ok ? base[item.operand_a[IDX_W-1:0]] : '0;
        vb = b_ok ? base[item.operand_b[IDX_W-1:0]] : '0;

        for (int i = 0; i < REGISTER_COUNT; i++)
            after_dst[i] = (dst_ok && item.dest_index == srie_pkg::DEST_W'(i)) ? res : base[i];

        next_pointer = ip_ok ? after_dst[ip_select[IDX_W-1:0]] + DW'(1) : DW'(1);

        for (int i = 0; i < REGISTER_COUNT; i++)
            rf_next[i] = (ip_ok && ip_select == srie_pkg::IP_SEL_W'(i)) ? next_pointer
                                                                        : after_dst[i];

        reg_zero     = rf_next[0];
        halted       = next_pointer[DW-1] || (next_pointer >= DW'(program_length));
        running_next = exec_en ? !halted : running_reg;
    end

    always_ff @(posedge clk)
    begin
        if (exec_en)
        begin
            for (int i = 0; i < REGISTER_COUNT; i++)
                rf_reg[i] <= rf_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            running_reg <= 1'b0;
        else
            running_reg <= running_next;
    end

endmodule

/* rtl/core/six_register_instruction_executor.sv */
// Channel  | Dir | Beat payload
// ---------+-----+---------------------------------------------------------
// item     | in  | opcode, operand_a, operand_b, dest_index
// result   | out | written_value, next_pointer, halted, reg_zero_value
// cfg      | in  | cfg_write, cfg_index, cfg_data (write only)
//
// One instruction per cycle while the output register is free; mulr/muli first load
// the registered partial products, so a multiply holds the input register meanwhile.
// Path: an item beat loads the input register, and execute then writes the result
// into the output register; a multiply first loads the partial-product registers
// in between.
// Stalls: the input register refills while a finished result waits in the
// output register; item ready drops only while both are full and the result is
// not taken, or while a multiply loads its partial products.
// Reset clears config and run state; register contents are rebuilt at run start.
`include "six_register_instruction_executor_defines.svh"

module six_register_instruction_executor #(
    parameter int REGISTER_COUNT = srie_pkg::DEF_REGISTER_COUNT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_write,
    input  logic [srie_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [srie_pkg::CFG_DATA_W-1:0] cfg_data,
    srie_in_if.sink                         item,
    srie_out_if.source                      result
);

    localparam int DW = srie_pkg::DATA_W;

    logic [srie_pkg::IP_SEL_W-1:0]   ip_select_reg;
    logic [srie_pkg::PROG_LEN_W-1:0] program_length_reg;
    logic [srie_pkg::INIT_R0_W-1:0]  init_r0_reg;

    srie_pkg::item_t ir_reg;
    logic            ir_valid_reg;
    logic            ir_valid_next;
    logic            mul_pending_reg;
    logic            mul_pending_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic [DW-1:0]   written_value_reg;
    logic [DW-1:0]   next_pointer_reg;
    logic            halted_reg;
    logic [DW-1:0]   reg_zero_reg;

    logic          ir_mul;
    logic          out_free;
    logic          exec_fire;
    logic          mul_load;
    logic          item_fire;
    logic [DW-1:0] va;
    logic [DW-1:0] vb;
    logic [DW-1:0] mul_b;
    logic [DW-1:0] mul_product;
    logic [DW-1:0] res;
    logic [DW-1:0] ptr;
    logic [DW-1:0] reg_zero;
    logic          halted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ip_select_reg      <= '0;
            program_length_reg <= '0;
            init_r0_reg        <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                srie_pkg::CFG_IP_SELECT:   ip_select_reg      <= cfg_data[srie_pkg::IP_SEL_W-1:0];
                srie_pkg::CFG_PROG_LENGTH: program_length_reg <= cfg_data;
                srie_pkg::CFG_INIT_R0:     init_r0_reg        <= cfg_data[srie_pkg::INIT_R0_W-1:0];
                default:                   ;
            endcase
        end
    end

    always_comb
    begin
        ir_mul     = srie_pkg::is_mul(ir_reg.opcode);
        out_free   = !out_valid_reg || result.ready;
        exec_fire  = ir_valid_reg && (!ir_mul || mul_pending_reg) && out_free;
        mul_load   = ir_valid_reg && ir_mul && !mul_pending_reg;
        item.ready = !ir_valid_reg || exec_fire;
        item_fire  = item.valid && item.ready;

        ir_valid_next    = item_fire ? 1'b1 : (exec_fire ? 1'b0 : ir_valid_reg);
        mul_pending_next = mul_load ? 1'b1 : (exec_fire ? 1'b0 : mul_pending_reg);
        out_valid_next   = exec_fire ? 1'b1 : (result.ready ? 1'b0 : out_valid_reg);

        mul_b = (ir_reg.opcode == srie_pkg::OP_MULI) ? srie_pkg::sext32(ir_reg.operand_b) : vb;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ir_valid_reg    <= 1'b0;
            mul_pending_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            ir_valid_reg    <= ir_valid_next;
            mul_pending_reg <= mul_pending_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            ir_reg.opcode     <= item.opcode;
            ir_reg.operand_a  <= item.operand_a;
            ir_reg.operand_b  <= item.operand_b;
            ir_reg.dest_index <= item.dest_index;
        end
        if (exec_fire)
        begin
            written_value_reg <= res;
            next_pointer_reg  <= ptr;
            halted_reg        <= halted;
            reg_zero_reg      <= reg_zero;
        end
    end

    srie_regfile #(
        .REGISTER_COUNT (REGISTER_COUNT)
    ) u_regfile (
        .clk              (clk),
        .rst_n            (rst_n),
        .exec_en          (exec_fire),
        .item             (ir_reg),
        .res              (res),
        .ip_select        (ip_select_reg),
        .program_length   (program_length_reg),
        .initial_reg_zero (init_r0_reg),
        .va               (va),
        .vb               (vb),
        .next_pointer     (ptr),
        .reg_zero         (reg_zero),
        .halted           (halted)
    );

    srie_mul u_mul (
        .clk     (clk),
        .load    (mul_load),
        .a       (va),
        .b       (mul_b),
        .product (mul_product)
    );

    srie_alu u_alu (
        .item        (ir_reg),
        .va          (va),
        .vb          (vb),
        .mul_product (mul_product),
        .res         (res)
    );

    assign result.valid          = out_valid_reg;
    assign result.written_value  = written_value_reg;
    assign result.next_pointer   = next_pointer_reg;
    assign result.halted         = halted_reg;
    assign result.reg_zero_value = reg_zero_reg;

    `SRIE_ASSERT_NOW(a_mul_pending_has_mul, mul_pending_reg, ir_valid_reg && ir_mul, "multiply pending without a multiply in the input register")
    `SRIE_ASSERT_NEXT(a_fire_clears_pending, exec_fire, !mul_pending_reg, "multiply stage not released after execute")
    `SRIE_ASSERT_NEXT(a_halt_reaches_output, exec_fire && halted, result.valid && result.halted, "halted instruction did not reach the output register")

endmodule
